// ----- design/pngtx_pkg.sv -----
// shared constants, tables and types for the png text chunk value extractor
// no dependencies; used by pngtx_parser and png_text_chunk_value_extractor

package pngtx_pkg;

    // default chunk length width
    localparam int LENGTH_WIDTH_DEF = 32;

    // phase counter width: longest counted phase is the 25-byte header
    localparam int CNT_W = 5;

    // parse phase codes
    localparam int PH_W = 4;
    localparam logic [PH_W-1:0] PH_SIG    = 4'd0;
    localparam logic [PH_W-1:0] PH_IHDR   = 4'd1;
    localparam logic [PH_W-1:0] PH_LEN    = 4'd2;
    localparam logic [PH_W-1:0] PH_TYPE   = 4'd3;
    localparam logic [PH_W-1:0] PH_KEY    = 4'd4;
    localparam logic [PH_W-1:0] PH_PREFIX = 4'd5;
    localparam logic [PH_W-1:0] PH_VALUE  = 4'd6;
    localparam logic [PH_W-1:0] PH_DATA   = 4'd7;
    localparam logic [PH_W-1:0] PH_CRC    = 4'd8;
    localparam logic [PH_W-1:0] PH_DONE   = 4'd9;

    // result kinds
    localparam logic [2:0] RES_VALUE     = 3'd0;
    localparam logic [2:0] RES_EMPTY     = 3'd1;
    localparam logic [2:0] RES_NOT_FOUND = 3'd2;
    localparam logic [2:0] RES_BAD_SIG   = 3'd3;
    localparam logic [2:0] RES_BAD_ITXT  = 3'd4;
    localparam logic [2:0] RES_SHORT     = 3'd5;

    // chunk type words, big-endian
    localparam logic [31:0] TYPE_TEXT = 32'h7445_5874;
    localparam logic [31:0] TYPE_ITXT = 32'h6954_5874;
    localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

    // last byte indices of the fixed fields, and byte counts of keyword and prefix
    localparam logic [CNT_W-1:0] SIG_LAST    = 5'd7;
    localparam logic [CNT_W-1:0] IHDR_LAST   = 5'd24;
    localparam logic [CNT_W-1:0] FIELD4_LAST = 5'd3;
    localparam logic [CNT_W-1:0] KEY_LAST    = 5'd10;
    localparam int KEY_LEN    = 11;
    localparam int PREFIX_LEN = 4;

    // one result word
    typedef struct packed {
        logic [7:0] value_byte;
        logic [2:0] result_kind;
        logic       last;
    } pngtx_result_t;

    // png file signature
    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0: b = 8'h89;
            3'd1: b = 8'h50;
            3'd2: b = 8'h4E;
            3'd3: b = 8'h47;
            3'd4: b = 8'h0D;
            3'd5: b = 8'h0A;
            3'd6: b = 8'h1A;
            default: b = 8'h0A;
        endcase
        return b;
    endfunction

    // keyword "parameters" with its terminating nul
    function automatic logic [7:0] key_byte(input logic [3:0] idx);
        logic [7:0] b;
        unique case (idx)
            4'd0: b = 8'h70;
            4'd1: b = 8'h61;
            4'd2: b = 8'h72;
            4'd3: b = 8'h61;
            4'd4: b = 8'h6D;
            4'd5: b = 8'h65;
            4'd6: b = 8'h74;
            4'd7: b = 8'h65;
            4'd8: b = 8'h72;
            4'd9: b = 8'h73;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ----- design/pngtx_parser.sv -----
// per-byte chunk parser: phase state, counters and one step of decode logic
// depends on pngtx_pkg

module pngtx_parser
    import pngtx_pkg::*;
#(
    parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  logic [7:0]    file_byte,
    input  logic          file_start,
    output logic          res_valid,
    output pngtx_result_t res
);

    localparam logic [LENGTH_WIDTH-1:0] LEN_ZERO  = '0;
    localparam logic [LENGTH_WIDTH-1:0] LEN_ONE   = LENGTH_WIDTH'(1);
    localparam logic [LENGTH_WIDTH-1:0] LEN_KEY   = LENGTH_WIDTH'(KEY_LEN);
    localparam logic [LENGTH_WIDTH-1:0] LEN_KEYPF = LENGTH_WIDTH'(KEY_LEN + PREFIX_LEN);

    logic [PH_W-1:0]         phase_reg, phase_next, phase_cur;
    logic [CNT_W-1:0]        cnt_reg, cnt_next, cnt_cur;
    logic [LENGTH_WIDTH-1:0] len_reg, len_next, len_cur;
    logic [23:0]             type_reg, type_next, type_cur;
    logic                    itxt_reg, itxt_next, itxt_cur;
    logic                    match_reg, match_next, match_cur;
    logic [31:0]             type_word;
    logic                    key_ok;

    // file start restarts from the reset state for this byte
    assign phase_cur = file_start ? PH_SIG : phase_reg;
    assign cnt_cur   = file_start ? '0 : cnt_reg;
    assign len_cur   = file_start ? '0 : len_reg;
    assign type_cur  = file_start ? '0 : type_reg;
    assign itxt_cur  = file_start ? 1'b0 : itxt_reg;
    assign match_cur = file_start ? 1'b1 : match_reg;

    assign type_word = {type_cur, file_byte};
    assign key_ok    = match_cur && (file_byte == key_byte(cnt_cur[3:0]));

    // one parse step
    always_comb
    begin
        phase_next = phase_cur;
        cnt_next   = cnt_cur;
        len_next   = len_cur;
        type_next  = type_cur;
        itxt_next  = itxt_cur;
        match_next = match_cur;
        res_valid  = 1'b0;
        res        = '{value_byte: 8'h00, result_kind: RES_VALUE, last: 1'b1};
        unique case (phase_cur)
            PH_SIG:
            begin
                if (file_byte != sig_byte(cnt_cur[2:0]))
                begin
                    res_valid       = 1'b1;
                    res.result_kind = RES_BAD_SIG;
                    phase_next      = PH_DONE;
                end
                else if (cnt_cur == SIG_LAST)
                begin
                    cnt_next   = '0;
                    phase_next = PH_IHDR;
                end
                else
                begin
                    cnt_next = cnt_cur + 1'b1;
                end
            end
            PH_IHDR:
            begin
                if (cnt_cur == IHDR_LAST)
                begin
                    cnt_next   = '0;
                    len_next   = '0;
                    phase_next = PH_LEN;
                end
                else
                begin
                    cnt_next = cnt_cur + 1'b1;
                end
            end
            PH_LEN:
            begin
                len_next = {len_cur[LENGTH_WIDTH-9:0], file_byte};
                if (cnt_cur == FIELD4_LAST)
                begin
                    cnt_next   = '0;
                    type_next  = '0;
                    phase_next = PH_TYPE;
                end
                else
                begin
                    cnt_next = cnt_cur + 1'b1;
                end
            end
            PH_TYPE:
            begin
                type_next = type_word[23:0];
                if (cnt_cur != FIELD4_LAST)
                begin
                    cnt_next = cnt_cur + 1'b1;
                end
                else
                begin
                    cnt_next = '0;
                    if (type_word == TYPE_IEND)
                    begin
                        res_valid       = 1'b1;
                        res.result_kind = RES_NOT_FOUND;
                        phase_next      = PH_DONE;
                    end
                    else if (type_word == TYPE_TEXT || type_word == TYPE_ITXT)
                    begin
                        itxt_next = (type_word == TYPE_ITXT);
                        if (len_cur < LEN_KEY)
                        begin
                            res_valid       = 1'b1;
                            res.result_kind = RES_SHORT;
                            phase_next      = PH_DONE;
                        end
                        else
                        begin
                            match_next = 1'b1;
                            phase_next = PH_KEY;
                        end
                    end
                    else
                    begin
                        itxt_next  = 1'b0;
                        phase_next = (len_cur == LEN_ZERO) ? PH_CRC : PH_DATA;
                    end
                end
            end
            PH_KEY:
            begin
                match_next = key_ok;
                if (cnt_cur != KEY_LAST)
                begin
                    cnt_next = cnt_cur + 1'b1;
                end
                else
                begin
                    cnt_next = '0;
                    len_next = len_cur - LEN_KEY;
                    if (!key_ok)
                    begin
                        // skip what is left of the data, then the crc
                        phase_next = (len_cur == LEN_KEY) ? PH_CRC : PH_DATA;
                    end
                    else if (itxt_cur)
                    begin
                        if (len_cur < LEN_KEYPF)
                        begin
                            res_valid       = 1'b1;
                            res.result_kind = RES_SHORT;
                            phase_next      = PH_DONE;
                        end
                        else
                        begin
                            len_next   = len_cur - LEN_KEYPF;
                            phase_next = PH_PREFIX;
                        end
                    end
                    else if (len_cur == LEN_KEY)
                    begin
                        res_valid       = 1'b1;
                        res.result_kind = RES_EMPTY;
                        phase_next      = PH_DONE;
                    end
                    else
                    begin
                        phase_next = PH_VALUE;
                    end
                end
            end
            PH_PREFIX:
            begin
                if (file_byte != 8'h00)
                begin
                    res_valid       = 1'b1;
                    res.result_kind = RES_BAD_ITXT;
                    phase_next      = PH_DONE;
                end
                else if (cnt_cur != FIELD4_LAST)
                begin
                    cnt_next = cnt_cur + 1'b1;
                end
                else
                begin
                    cnt_next = '0;
                    if (len_cur == LEN_ZERO)
                    begin
                        res_valid       = 1'b1;
                        res.result_kind = RES_EMPTY;
                        phase_next      = PH_DONE;
                    end
                    else
                    begin
                        phase_next = PH_VALUE;
                    end
                end
            end
            PH_VALUE:
            begin
                len_next       = len_cur - LEN_ONE;
                res_valid      = 1'b1;
                res.value_byte = file_byte;
                res.last       = (len_cur == LEN_ONE);
                if (len_cur == LEN_ONE)
                begin
                    phase_next = PH_DONE;
                end
            end
            PH_DATA:
            begin
                len_next = len_cur - LEN_ONE;
                if (len_cur == LEN_ONE)
                begin
                    cnt_next   = '0;
                    phase_next = PH_CRC;
                end
            end
            PH_CRC:
            begin
                if (cnt_cur == FIELD4_LAST)
                begin
                    cnt_next   = '0;
                    len_next   = '0;
                    phase_next = PH_LEN;
                end
                else
                begin
                    cnt_next = cnt_cur + 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase
    end

    // parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SIG;
            cnt_reg   <= '0;
            len_reg   <= '0;
            type_reg  <= '0;
            itxt_reg  <= 1'b0;
            match_reg <= 1'b1;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            len_reg   <= len_next;
            type_reg  <= type_next;
            itxt_reg  <= itxt_next;
            match_reg <= match_next;
        end
    end

endmodule

// ----- design/png_text_chunk_value_extractor.sv -----
// top level: input word register, parser step, result word register
// depends on pngtx_pkg and pngtx_parser
//
//  channel | dir | tdata          | tuser            | tlast
//  s_*     | in  | file_byte[7:0] | file_start       | -
//  m_*     | out | value_byte[7:0]| result_kind[2:0] | last
//
// one byte per cycle; each byte is held in the input register and
// its result, if any, is registered in the result register
// the parser step sits between the two registers with no iteration
// reset clears both valid flags and returns parsing to the signature check
// the input side stalls only when a held byte and a waiting result coincide
// with m_tready low

module png_text_chunk_value_extractor
    import pngtx_pkg::*;
#(
    parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] file_byte
    input  logic       s_tuser,   // [0] file_start
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] value_byte
    output logic [2:0] m_tuser,   // [2:0] result_kind
    output logic       m_tlast
);

    logic          in_valid_reg, in_valid_next;
    logic [7:0]    in_byte_reg;
    logic          in_start_reg;
    logic          out_valid_reg, out_valid_next;
    pngtx_result_t out_reg;
    logic          advance;
    logic          step;
    logic          res_valid;
    pngtx_result_t res;

    // handshake control
    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step)
        begin
            out_valid_next = res_valid;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // parser
    pngtx_parser #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .file_byte  (in_byte_reg),
        .file_start (in_start_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input word
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser;
        end
    end

    // result word
    always_ff @(posedge clk)
    begin
        if (step && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.value_byte;
    assign m_tuser  = out_reg.result_kind;
    assign m_tlast  = out_reg.last;

endmodule

// ----- bench/testbench.sv -----
// self-checking bench for png_text_chunk_value_extractor: byte-stream files in,
// parameters value words out, checked against a built-in parser model
// depends on pngtx_pkg and the png_text_chunk_value_extractor rtl

module testbench
    import pngtx_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEN_W       = LENGTH_WIDTH_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;

    localparam logic [63:0] SIG_WORD     = 64'h8950_4E47_0D0A_1A0A;
    localparam logic [87:0] KEYWORD_TEXT = {"parameters", 8'h00};

    typedef enum logic [1:0] {CK_OTHER, CK_TEXT, CK_ITXT} text_kind_t;
    typedef enum {TX_GOOD, TX_KEY_MISS, TX_BAD_PREFIX, TX_SHORT, TX_SHORT_PREFIX} text_mode_t;

    // one input word plus its pacing
    typedef struct {
        logic [7:0] data;
        logic       start;
        int         gap;
        bit         drain;
    } file_byte_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;   // [7:0] file_byte
    logic       s_tuser = 1'b0;    // [0] file_start
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;           // [7:0] value_byte
    logic [2:0] m_tuser;           // [2:0] result_kind
    logic       m_tlast;

    file_byte_t     file_byte_q[$];
    pngtx_result_t  expected_words[$];
    file_byte_t     cur_byte;
    pngtx_result_t  want;

    // parser model state
    logic [PH_W-1:0]  phase;
    int               cnt;
    logic [LEN_W-1:0] chunk_len;
    logic [31:0]      type_word;
    text_kind_t       text_kind;
    bit               key_ok;

    // stimulus and pacing state
    bit tx_quiet;
    bit hold_for_drain;
    bit value_extremes;
    int tx_wait;
    int rx_wait;
    bit rx_quiet;
    int hold_left;
    int results_seen;
    int errors;
    int cycle_count;
    int target;

    png_text_chunk_value_extractor #(
        .LENGTH_WIDTH(LEN_W)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ---------------- parser model ----------------

    task automatic restart_parser();
        phase     = PH_SIG;
        cnt       = 0;
        chunk_len = '0;
        type_word = '0;
        text_kind = CK_OTHER;
        key_ok    = 1'b1;
    endtask

    // final word of a file, parser goes quiet until the next start
    function automatic pngtx_result_t closing_word(input logic [2:0] kind);
        pngtx_result_t w;
        phase = PH_DONE;
        w.value_byte  = 8'h00;
        w.result_kind = kind;
        w.last        = 1'b1;
        return w;
    endfunction

    // skip remaining data then the crc
    task automatic skip_chunk_rest();
        cnt   = 0;
        phase = (chunk_len == 0) ? PH_CRC : PH_DATA;
    endtask

    // advance the parser by one accepted word, queue the word it yields
    task automatic parse_file_byte(input logic [7:0] b, input logic st);
        pngtx_result_t word;
        bit produced;
        produced = 1'b0;
        word = '0;
        if (st)
            restart_parser();
        case (phase)
            PH_SIG:
            begin
                if (b != SIG_WORD[63 - 8 * (cnt % 8) -: 8])
                begin
                    produced = 1'b1;
                    word = closing_word(RES_BAD_SIG);
                end
                else
                begin
                    cnt++;
                    if (cnt >= 8)
                    begin
                        cnt   = 0;
                        phase = PH_IHDR;
                    end
                end
            end
            PH_IHDR:
            begin
                cnt++;
                if (cnt >= 25)
                begin
                    cnt       = 0;
                    chunk_len = '0;
                    phase     = PH_LEN;
                end
            end
            PH_LEN:
            begin
                chunk_len = (chunk_len << 8) | b;
                cnt++;
                if (cnt >= 4)
                begin
                    cnt       = 0;
                    type_word = '0;
                    phase     = PH_TYPE;
                end
            end
            PH_TYPE:
            begin
                type_word = {type_word[23:0], b};
                cnt++;
                if (cnt >= 4)
                begin
                    cnt = 0;
                    if (type_word == TYPE_IEND)
                    begin
                        produced = 1'b1;
                        word = closing_word(RES_NOT_FOUND);
                    end
                    else if (type_word == TYPE_TEXT || type_word == TYPE_ITXT)
                    begin
                        text_kind = (type_word == TYPE_TEXT) ? CK_TEXT : CK_ITXT;
                        if (chunk_len < KEY_LEN)
                        begin
                            produced = 1'b1;
                            word = closing_word(RES_SHORT);
                        end
                        else
                        begin
                            key_ok = 1'b1;
                            phase  = PH_KEY;
                        end
                    end
                    else
                    begin
                        text_kind = CK_OTHER;
                        skip_chunk_rest();
                    end
                end
            end
            PH_KEY:
            begin
                if (b != KEYWORD_TEXT[87 - 8 * cnt -: 8])
                    key_ok = 1'b0;
                cnt++;
                if (cnt >= KEY_LEN)
                begin
                    cnt = 0;
                    chunk_len = chunk_len - KEY_LEN;
                    if (!key_ok)
                        skip_chunk_rest();
                    else if (text_kind == CK_ITXT)
                    begin
                        if (chunk_len < PREFIX_LEN)
                        begin
                            produced = 1'b1;
                            word = closing_word(RES_SHORT);
                        end
                        else
                        begin
                            chunk_len = chunk_len - PREFIX_LEN;
                            phase = PH_PREFIX;
                        end
                    end
                    else if (chunk_len == 0)
                    begin
                        produced = 1'b1;
                        word = closing_word(RES_EMPTY);
                    end
                    else
                        phase = PH_VALUE;
                end
            end
            PH_PREFIX:
            begin
                if (b != 8'h00)
                begin
                    produced = 1'b1;
                    word = closing_word(RES_BAD_ITXT);
                end
                else
                begin
                    cnt++;
                    if (cnt >= PREFIX_LEN)
                    begin
                        cnt = 0;
                        if (chunk_len == 0)
                        begin
                            produced = 1'b1;
                            word = closing_word(RES_EMPTY);
                        end
                        else
                            phase = PH_VALUE;
                    end
                end
            end
            PH_VALUE:
            begin
                chunk_len = chunk_len - 1'b1;
                produced = 1'b1;
                word.value_byte  = b;
                word.result_kind = RES_VALUE;
                word.last        = (chunk_len == 0);
                if (chunk_len == 0)
                    phase = PH_DONE;
            end
            PH_DATA:
            begin
                chunk_len = chunk_len - 1'b1;
                if (chunk_len == 0)
                begin
                    cnt   = 0;
                    phase = PH_CRC;
                end
            end
            PH_CRC:
            begin
                cnt++;
                if (cnt >= 4)
                begin
                    cnt       = 0;
                    chunk_len = '0;
                    phase     = PH_LEN;
                end
            end
            default:
                phase = PH_DONE;
        endcase
        if (produced)
            expected_words.push_back(word);
    endtask

    // ---------------- file builders ----------------

    task automatic put(input logic [7:0] b, input logic st);
        file_byte_t it;
        it.data  = b;
        it.start = st;
        it.gap   = tx_quiet ? 0 : $urandom_range(0, 19);
        it.drain = hold_for_drain;
        hold_for_drain = 1'b0;
        file_byte_q.push_back(it);
    endtask

    // big-endian 32-bit field
    task automatic put_word(input logic [31:0] w);
        for (int i = 3; i >= 0; i--)
            put(w[8 * i +: 8], 1'b0);
    endtask

    // signature, optionally broken at one position where the file then ends, else followed by the header chunk
    task automatic start_file(input logic st, input int bad_at);
        logic [7:0] b;
        for (int i = 0; i < 8; i++)
        begin
            b = SIG_WORD[63 - 8 * i -: 8];
            if (i == bad_at)
                b = b ^ 8'($urandom_range(1, 255));
            put(b, (i == 0) ? st : 1'b0);
            if (i == bad_at)
                return;
        end
        repeat (25) put(8'($urandom), 1'b0);
    endtask

    // chunk of some type the parser skips
    task automatic put_other(input int len);
        logic [31:0] tw;
        do
            tw = $urandom;
        while (tw == TYPE_IEND || tw == TYPE_TEXT || tw == TYPE_ITXT);
        put_word(len);
        put_word(tw);
        repeat (len + 4) put(8'($urandom), 1'b0);
    endtask

    task automatic put_iend();
        put_word($urandom_range(0, 3));
        put_word(TYPE_IEND);
    endtask

    // text chunk; mode picks the good or broken form
    task automatic put_text(input bit itxt, input text_mode_t mode, input int nval);
        logic [31:0] len;
        logic [7:0]  b;
        int          bad_pos;
        bad_pos = $urandom_range(0, KEY_LEN - 1);
        case (mode)
            TX_SHORT:        len = $urandom_range(0, KEY_LEN - 1);
            TX_SHORT_PREFIX: len = KEY_LEN + $urandom_range(0, PREFIX_LEN - 1);
            TX_KEY_MISS:     len = KEY_LEN + nval;
            default:         len = KEY_LEN + (itxt ? PREFIX_LEN : 0) + nval;
        endcase
        put_word(len);
        put_word(itxt ? TYPE_ITXT : TYPE_TEXT);
        if (mode == TX_SHORT)
            return;
        for (int i = 0; i < KEY_LEN; i++)
        begin
            b = KEYWORD_TEXT[87 - 8 * i -: 8];
            if (mode == TX_KEY_MISS && i == bad_pos)
                b = b ^ 8'($urandom_range(1, 255));
            put(b, 1'b0);
        end
        if (mode == TX_SHORT_PREFIX)
            return;
        if (mode == TX_KEY_MISS)
        begin
            repeat (nval + 4) put(8'($urandom), 1'b0);
            return;
        end
        // itxt flags and the two empty tags
        if (itxt)
        begin
            for (int i = 0; i < PREFIX_LEN; i++)
            begin
                if (mode == TX_BAD_PREFIX && i == bad_pos % PREFIX_LEN)
                    put(8'($urandom_range(1, 255)), 1'b0);
                else
                    put(8'h00, 1'b0);
            end
        end
        for (int i = 0; i < nval; i++)
        begin
            b = 8'($urandom);
            if (value_extremes && i == 0)
                b = 8'h00;
            if (value_extremes && i == nval - 1)
                b = 8'hFF;
            put(b, 1'b0);
        end
        repeat (4) put(8'($urandom), 1'b0);
    endtask

    // mostly well-formed file with random content, some broken or cut short
    task automatic random_file();
        int pick;
        tx_quiet = ($urandom_range(0, 2) == 0);
        if ($urandom_range(0, 3) == 0)
            hold_for_drain = 1'b1;
        if ($urandom_range(0, 9) == 0)
        begin
            start_file(1'b1, $urandom_range(0, 7));
        end
        else
        begin
            start_file(1'b1, -1);
            repeat ($urandom_range(0, 2)) put_other($urandom_range(0, 8));
            if ($urandom_range(0, 2) == 0)
                put_text($urandom_range(0, 1), TX_KEY_MISS, $urandom_range(0, 6));
            pick = $urandom_range(0, 99);
            if (pick < 55)
                put_text($urandom_range(0, 1), TX_GOOD,
                         ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 24));
            else if (pick < 65)
                put_iend();
            else if (pick < 75)
                put_text(1'b1, TX_BAD_PREFIX, $urandom_range(0, 4));
            else if (pick < 85)
                put_text($urandom_range(0, 1), TX_SHORT, 0);
            else if (pick < 92)
                put_text(1'b1, TX_SHORT_PREFIX, 0);
            else
                repeat ($urandom_range(1, 6)) put(8'($urandom), 1'b0);
        end
        // trailing noise, ignored once the file is finished
        repeat ($urandom_range(0, 3)) put(8'($urandom), 1'b0);
    endtask

    // ---------------- driver ----------------

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            tx_wait = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                parse_file_byte(s_tdata, s_tuser);
            if (!s_tvalid || s_tready)
            begin
                if (tx_wait > 0)
                begin
                    tx_wait--;
                    s_tvalid <= 1'b0;
                end
                else if (file_byte_q.size() != 0 &&
                         (!file_byte_q[0].drain || expected_words.size() == 0))
                begin
                    cur_byte = file_byte_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= cur_byte.data;
                    s_tuser  <= cur_byte.start;
                    if (file_byte_q.size() != 0)
                        tx_wait = file_byte_q[0].gap;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------- monitor ----------------

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_wait = 0;
            hold_left = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none, actual data %h kind %0d last %b",
                             $time, m_tdata, m_tuser, m_tlast);
                    errors++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (m_tdata !== want.value_byte)
                    begin
                        $display("%0t: value_byte expected %h actual %h",
                                 $time, want.value_byte, m_tdata);
                        errors++;
                    end
                    if (m_tuser !== want.result_kind)
                    begin
                        $display("%0t: result_kind expected %0d actual %0d",
                                 $time, want.result_kind, m_tuser);
                        errors++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $display("%0t: last expected %b actual %b", $time, want.last, m_tlast);
                        errors++;
                    end
                end
                results_seen++;
                // long back-pressure so the block fills and stalls its input
                if (results_seen == 12 || results_seen == 150)
                    hold_left = HOLD_CYCLES;
                if ($urandom_range(0, 39) == 0)
                    rx_quiet = !rx_quiet;
                rx_wait = rx_quiet ? 0 : $urandom_range(0, 19);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // ---------------- watchdog ----------------

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ---------------- stimulus and end of run ----------------

    initial
    begin
        restart_parser();

        // first file right after reset with no start mark, value with extreme bytes
        value_extremes = 1'b1;
        start_file(1'b0, -1);
        put_text(1'b0, TX_GOOD, 4);
        value_extremes = 1'b0;

        // signature broken on the first and on the last byte
        start_file(1'b1, 0);
        put(8'hFF, 1'b0);
        start_file(1'b1, 7);

        // empty values, zero-length skipped chunk, keyword misses then a match
        hold_for_drain = 1'b1;
        start_file(1'b1, -1);
        put_other(0);
        put_text(1'b0, TX_GOOD, 0);
        start_file(1'b1, -1);
        put_text(1'b1, TX_GOOD, 0);
        start_file(1'b1, -1);
        put_text(1'b1, TX_KEY_MISS, 0);
        put_text(1'b0, TX_KEY_MISS, 3);
        put_text(1'b1, TX_GOOD, 3);

        // iend, bad itxt prefix, short text chunks
        start_file(1'b1, -1);
        put_other(2);
        put_iend();
        start_file(1'b1, -1);
        put_text(1'b1, TX_BAD_PREFIX, 2);
        start_file(1'b1, -1);
        put_text(1'b0, TX_SHORT, 0);
        start_file(1'b1, -1);
        put_text(1'b1, TX_SHORT, 0);
        start_file(1'b1, -1);
        put_text(1'b1, TX_SHORT_PREFIX, 0);

        // huge lengths, each cut off by the next file start
        start_file(1'b1, -1);
        put_word(32'hFFFF_FFFF);
        put_word(32'h1234_5678);
        repeat (6) put(8'($urandom), 1'b0);
        start_file(1'b1, -1);
        put_word(32'h8000_0000);
        put_word(TYPE_TEXT);
        for (int i = 0; i < KEY_LEN; i++)
            put(KEYWORD_TEXT[87 - 8 * i -: 8], 1'b0);
        repeat (5) put(8'($urandom), 1'b0);

        // random files
        target = file_byte_q.size() + 550;
        while (file_byte_q.size() < target)
            random_file();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (file_byte_q.size() != 0 || s_tvalid)
            @(posedge clk);
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
design/pngtx_pkg.sv
design/pngtx_parser.sv
design/png_text_chunk_value_extractor.sv
bench/testbench.sv
